// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define RRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define RRS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/rrs_pkg.sv =====
// Shared types and constants for the replay retry scheduler.
// Used by every module of the block; depends on nothing.
package rrs_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int RECORD_BITS_DEF = 64;
   localparam int WORD_BITS       = 64;
   localparam int TIME_BITS       = 32;
   localparam int LEVEL_BITS      = 7;
   localparam int FAIL_BITS       = 4;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [15:0] RETRY_DELAY_RST   = 16'd5000;
   localparam logic [15:0] SEND_INTERVAL_RST = 16'd100;
   localparam logic [3:0]  MAX_FAILURES_RST  = 4'd3;
   localparam logic [3:0]  FAIL_SAT          = 4'd15;

   typedef enum logic [2:0] {
      CMD_NEW        = 3'd0,
      CMD_TICK       = 3'd1,
      CMD_RECONNECT  = 3'd2,
      CMD_DISCONNECT = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RETRY_DELAY   = 2'd0,
      CSR_SEND_INTERVAL = 2'd1,
      CSR_MAX_FAILURES  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]           command;
      logic [TIME_BITS-1:0] now_time;
      logic                 link_up;
      logic [WORD_BITS-1:0] sample_word;
      logic                 send_ack;
   } req_word_type;

   typedef struct packed {
      logic                  send_valid;
      logic [WORD_BITS-1:0]  send_word;
      logic                  queued;
      logic                  dropped_full;
      logic                  is_suspended;
      logic                  is_replaying;
      logic                  holding_record;
      logic [LEVEL_BITS-1:0] queue_level;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]          retry_delay;
      logic [15:0]          send_interval;
      logic [FAIL_BITS-1:0] max_failures;
   } cfg_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [WORD_BITS-1:0] data;
   } fifo_cmd_type;

endpackage

// ===== hw/rtl/replay_retry_scheduler_unit.sv =====
// A word's result is registered in the output register, or in the skid stage while the output is stalled.
// One word per cycle while req_stall is low; the scheduler state and FIFO head update per accepted word.
// The result queue holds two words, so req_stall rises only when both are waiting.
// Reset: synchronous, active high; clears control state, pointers, fill count and
// registers to their defaults. The record memory is not cleared: entries are read only
// after they have been written, so no clearing pass runs.
module replay_retry_scheduler_unit #(
   parameter int QUEUE_DEPTH = rrs_pkg::QUEUE_DEPTH_DEF,
   parameter int RECORD_BITS = rrs_pkg::RECORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rrs_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rrs_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [rrs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rrs_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import rrs_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type                cfg_ff;
   logic                   accept;
   logic                   outq_full;
   fifo_cmd_type           fifo_cmd;
   logic [CW-1:0]          fifo_count;
   logic [RECORD_BITS-1:0] fifo_head;
   rsp_word_type           result;

   // Configuration registers, no read-back: the user must write them only while idle; the block does not enforce it.
   // Indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_delay   <= RETRY_DELAY_RST;
         cfg_ff.send_interval <= SEND_INTERVAL_RST;
         cfg_ff.max_failures  <= MAX_FAILURES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RETRY_DELAY:   cfg_ff.retry_delay   <= csr_data;
            CSR_SEND_INTERVAL: cfg_ff.send_interval <= csr_data;
            CSR_MAX_FAILURES:  cfg_ff.max_failures  <= csr_data[FAIL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Take a word whenever the skid stage is free; the output register may still be
   // waiting on the downstream side.
   assign req_stall = outq_full;
   assign accept    = req_valid && !req_stall;

   // Record FIFO. The memory read is aimed each cycle at the head pointer of the
   // next cycle, and a same-entry write is forwarded, so the head record is ready
   // for a pop in every cycle.
   rrs_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .RECORD_BITS (RECORD_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .fifo_cmd   (fifo_cmd),
      .fifo_count (fifo_count),
      .fifo_head  (fifo_head)
   );

   // Scheduler: decode the command, decide direct send, queue, replay pop or retry,
   // and commit the state only for an accepted word.
   rrs_sched #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .RECORD_BITS (RECORD_BITS)
   ) u_sched (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .fifo_count (fifo_count),
      .fifo_head  (fifo_head),
      .fifo_cmd   (fifo_cmd),
      .rsp_word   (result)
   );

   // Result queue: hold the result until the downstream side takes it.
   rrs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (result),
      .in_full   (outq_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== hw/rtl/rrs_fifo.sv =====
// Record FIFO: one synchronous memory, pointers, fill count and head forwarding.
// Depends on rrs_pkg.
module rrs_fifo #(
   parameter int QUEUE_DEPTH = 64,
   parameter int RECORD_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrs_pkg::fifo_cmd_type            fifo_cmd,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] fifo_count,
   output logic [RECORD_BITS-1:0]           fifo_head
);
   import rrs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [RECORD_BITS-1:0] mem [QUEUE_DEPTH];

   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [RECORD_BITS-1:0] rd_data_ff;
   logic                   fwd_ff;
   logic [RECORD_BITS-1:0] fwd_data_ff;
   logic [RECORD_BITS-1:0] wr_data;

   assign wr_data = fifo_cmd.data[RECORD_BITS-1:0];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (fifo_cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         count_in  = count_ff - CW'(1);
      end
      if (fifo_cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         count_in  = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         fwd_ff    <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         // the read below sees old data when the same entry is written now
         fwd_ff    <= fifo_cmd.push && (wr_ptr_ff == rd_ptr_in);
      end
   end

   // memory: one write port, one registered read port aimed at the next head
   always_ff @(posedge clock) begin
      if (fifo_cmd.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      rd_data_ff  <= mem[rd_ptr_in];
      fwd_data_ff <= wr_data;
   end

   assign fifo_head  = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign fifo_count = count_ff;

endmodule

// ===== hw/rtl/rrs_sched.sv =====
// Scheduler state: link, replay, retry backoff and in-flight record.
// Depends on rrs_pkg; drives the FIFO command of rrs_fifo.
module rrs_sched #(
   parameter int QUEUE_DEPTH = 64,
   parameter int RECORD_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  rrs_pkg::req_word_type            req_word,
   input  rrs_pkg::cfg_type                 cfg,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] fifo_count,
   input  logic [RECORD_BITS-1:0]           fifo_head,
   output rrs_pkg::fifo_cmd_type            fifo_cmd,
   output rrs_pkg::rsp_word_type            rsp_word
);
   import rrs_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                   pend_v_ff, pend_v_in;
   logic [RECORD_BITS-1:0] pend_rec_ff, pend_rec_in;
   logic                   replay_ff, replay_in;
   logic                   begun_ff, begun_in;
   logic                   halted_ff, halted_in;
   logic [FAIL_BITS-1:0]   fail_run_ff, fail_run_in;
   logic [TIME_BITS-1:0]   start_time_ff, start_time_in;
   logic [TIME_BITS-1:0]   last_send_ff, last_send_in;
   logic [TIME_BITS-1:0]   last_fail_ff, last_fail_in;

   cmd_type                cmd;
   logic [TIME_BITS-1:0]   now;
   logic [RECORD_BITS-1:0] sample;
   logic [TIME_BITS-1:0]   since_start, since_send, since_fail;
   logic                   start_wait, send_wait, fail_wait;
   logic                   full;
   logic                   do_push, do_pop, do_try, go_offline;
   logic [RECORD_BITS-1:0] push_rec, try_rec, send_rec;
   logic                   send_v, queued, dropped;
   logic [FAIL_BITS-1:0]   fail_inc;
   logic [CW-1:0]          level;

   assign cmd    = cmd_type'(req_word.command);
   assign now    = req_word.now_time;
   assign sample = req_word.sample_word[RECORD_BITS-1:0];
   assign full   = (fifo_count == CW'(QUEUE_DEPTH));

   assign since_start = now - start_time_ff;
   assign since_send  = now - last_send_ff;
   assign since_fail  = now - last_fail_ff;
   assign start_wait  = since_start < TIME_BITS'(cfg.retry_delay);
   assign send_wait   = (last_send_ff != '0) && (since_send < TIME_BITS'(cfg.send_interval));
   assign fail_wait   = (last_fail_ff != '0) && (since_fail < TIME_BITS'(cfg.retry_delay));
   assign fail_inc    = (fail_run_ff == FAIL_SAT) ? fail_run_ff : fail_run_ff + FAIL_BITS'(1);

   always_comb begin
      pend_v_in     = pend_v_ff;
      pend_rec_in   = pend_rec_ff;
      replay_in     = replay_ff;
      begun_in      = begun_ff;
      halted_in     = halted_ff;
      fail_run_in   = fail_run_ff;
      start_time_in = start_time_ff;
      last_send_in  = last_send_ff;
      last_fail_in  = last_fail_ff;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      do_try        = 1'b0;
      go_offline    = 1'b0;
      push_rec      = sample;
      try_rec       = pend_rec_ff;
      send_v        = 1'b0;
      send_rec      = '0;
      queued        = 1'b0;
      dropped       = 1'b0;

      unique case (cmd)
         CMD_NEW: begin
            if (req_word.link_up && (fifo_count == '0) && !pend_v_ff && !replay_ff) begin
               send_v   = 1'b1;
               send_rec = sample;
               do_push  = !req_word.send_ack;
            end else begin
               do_push = 1'b1;
            end
         end
         CMD_TICK: begin
            if (!req_word.link_up) begin
               go_offline = replay_ff || pend_v_ff;
            end else if (!halted_ff && replay_ff && !(!begun_ff && start_wait)) begin
               begun_in = 1'b1;
               if (!fail_wait) begin
                  if (pend_v_ff) begin
                     do_try = 1'b1;
                  end else if (fifo_count != '0) begin
                     if (!send_wait) begin
                        do_pop  = 1'b1;
                        do_try  = 1'b1;
                        try_rec = fifo_head;
                     end
                  end else begin
                     replay_in = 1'b0;
                  end
               end
            end
         end
         CMD_RECONNECT: begin
            replay_in     = 1'b1;
            begun_in      = 1'b0;
            start_time_in = now;
            fail_run_in   = '0;
            halted_in     = 1'b0;
            last_fail_in  = '0;
         end
         CMD_DISCONNECT: begin
            go_offline = 1'b1;
         end
         CMD_CLEAR: begin
            fail_run_in   = '0;
            halted_in     = 1'b0;
            replay_in     = 1'b0;
            begun_in      = 1'b0;
            pend_v_in     = 1'b0;
            last_send_in  = '0;
            start_time_in = '0;
            last_fail_in  = '0;
         end
         default: begin
         end
      endcase

      // return the in-flight record to the tail and drop out of replay
      if (go_offline) begin
         if (pend_v_ff) begin
            do_push   = 1'b1;
            push_rec  = pend_rec_ff;
            pend_v_in = 1'b0;
         end
         replay_in = 1'b0;
         begun_in  = 1'b0;
      end

      if (do_try) begin
         send_v   = 1'b1;
         send_rec = try_rec;
         if (req_word.send_ack) begin
            pend_v_in    = 1'b0;
            fail_run_in  = '0;
            last_send_in = now;
            last_fail_in = '0;
         end else begin
            pend_v_in    = 1'b1;
            pend_rec_in  = try_rec;
            fail_run_in  = fail_inc;
            last_fail_in = now;
            if (fail_inc >= cfg.max_failures) begin
               halted_in = 1'b1;
            end
         end
      end

      if (do_push) begin
         if (full) begin
            dropped = 1'b1;
            do_push = 1'b0;
         end else begin
            queued = 1'b1;
         end
      end
   end

   always_comb begin
      level = fifo_count;
      if (do_push) begin
         level = fifo_count + CW'(1);
      end else if (do_pop) begin
         level = fifo_count - CW'(1);
      end
   end

   assign fifo_cmd.push = accept && do_push;
   assign fifo_cmd.pop  = accept && do_pop;
   assign fifo_cmd.data = WORD_BITS'(push_rec);

   assign rsp_word.send_valid     = send_v;
   assign rsp_word.send_word      = WORD_BITS'(send_rec);
   assign rsp_word.queued         = queued;
   assign rsp_word.dropped_full   = dropped;
   assign rsp_word.is_suspended   = halted_in;
   assign rsp_word.is_replaying   = replay_in;
   assign rsp_word.holding_record = pend_v_in;
   assign rsp_word.queue_level    = LEVEL_BITS'(level);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff     <= 1'b0;
         replay_ff     <= 1'b0;
         begun_ff      <= 1'b0;
         halted_ff     <= 1'b0;
         fail_run_ff   <= '0;
         start_time_ff <= '0;
         last_send_ff  <= '0;
         last_fail_ff  <= '0;
      end else if (accept) begin
         pend_v_ff     <= pend_v_in;
         replay_ff     <= replay_in;
         begun_ff      <= begun_in;
         halted_ff     <= halted_in;
         fail_run_ff   <= fail_run_in;
         start_time_ff <= start_time_in;
         last_send_ff  <= last_send_in;
         last_fail_ff  <= last_fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_rec_ff <= pend_rec_in;
      end
   end

endmodule

// ===== hw/rtl/rrs_outq.sv =====
// Two-entry result queue: output register plus skid stage.
// Depends on rrs_pkg.
module rrs_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rrs_pkg::rsp_word_type in_word,
   output logic                  in_full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrs_pkg::rsp_word_type rsp_word
);
   import rrs_pkg::*;

   logic         main_v_ff, skid_v_ff;
   rsp_word_type main_ff, skid_ff;
   logic         advance;

   assign advance = !main_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (advance) begin
         main_v_ff <= skid_v_ff || in_valid;
         skid_v_ff <= 1'b0;
      end else if (in_valid) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         main_ff <= skid_v_ff ? skid_ff : in_word;
      end else if (in_valid) begin
         skid_ff <= in_word;
      end
   end

   assign in_full   = skid_v_ff;
   assign rsp_valid = main_v_ff;
   assign rsp_word  = main_ff;

endmodule

// ===== hw/rtl/rrs_checker.sv =====
// Port-level checks for replay_retry_scheduler_unit, bound to the top level.
// Depends on rrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input rrs_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rrs_pkg::rsp_word_type rsp_word
);
   import rrs_pkg::*;

   // a waiting result must hold until taken
   `RRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // input backs up only when a result is waiting at the output
   `RRS_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid, "req_stall without a waiting result")

   `RRS_ASSERT(a_word_zero, clock, reset, (rsp_valid && !rsp_word.send_valid) |-> (rsp_word.send_word == '0), "send_word nonzero without send")

   `RRS_ASSERT(a_push_excl, clock, reset, rsp_valid |-> !(rsp_word.queued && rsp_word.dropped_full), "record both queued and dropped")

endmodule

bind replay_retry_scheduler_unit rrs_checker u_rrs_checker (.*);
